[hw/rtl/pixel_colour_space_converter_macros.svh]
// Assertion macros used by the converter top level.
`ifndef PIXEL_COLOUR_SPACE_CONVERTER_MACROS_SVH
`define PIXEL_COLOUR_SPACE_CONVERTER_MACROS_SVH

// Clocked property, checked outside reset.
`define PCSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define PCSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/pcsc_pkg.sv]
// Package with shared types, constants and helpers of the colour space converter.
`timescale 1ns / 1ps
`default_nettype none
package pcsc_pkg;

  localparam int unsigned FracBitsDef = 4;
  localparam int unsigned PixW        = 8;
  localparam int unsigned ChanW       = 12;
  localparam int unsigned ApbAw       = 3;
  localparam int unsigned ApbDw       = 32;
  localparam logic [ChanW-1:0] ChanMax = 12'hFFF;

  localparam logic RegColourMode = 1'b0;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_OPP  = 2'd1,
    MODE_HSV  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ChanW-1:0] v;
    logic             max_zero;
    logic             chroma_zero;
    logic [ChanW-1:0] alt0;
    logic [ChanW-1:0] alt1;
    logic [ChanW-1:0] alt2;
  } pcsc_side_t;

  function automatic logic [ChanW-1:0] sat_chan(logic [31:0] v);
    logic [ChanW-1:0] r;
    r = (v > 32'(ChanMax)) ? ChanMax : v[ChanW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pcsc_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module pcsc_div #(
  parameter int unsigned NW = 20,
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 12
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] low_d [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] quo_d [QW];
  logic [DW-1:0] den_q [QW];
  logic [DW-1:0] den_d [QW];

  always_comb begin
    logic [DW-1:0] rem_s;
    logic [QW-1:0] low_s;
    logic [QW-1:0] quo_s;
    logic [DW-1:0] den_s;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        rem_s = DW'(num_i[NW-1:QW]);
        low_s = num_i[QW-1:0];
        quo_s = '0;
        den_s = den_i;
      end else begin
        rem_s = rem_q[i-1];
        low_s = low_q[i-1];
        quo_s = quo_q[i-1];
        den_s = den_q[i-1];
      end
      trial    = {rem_s, low_s[QW-1]};
      diff     = trial - {1'b0, den_s};
      ge       = (trial >= {1'b0, den_s});
      rem_d[i] = ge ? diff[DW-1:0] : trial[DW-1:0];
      low_d[i] = {low_s[QW-2:0], 1'b0};
      quo_d[i] = {quo_s[QW-2:0], ge};
      den_d[i] = den_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QW; i++) begin
        rem_q[i] <= rem_d[i];
        low_q[i] <= low_d[i];
        quo_q[i] <= quo_d[i];
        den_q[i] <= den_d[i];
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule
`default_nettype wire

[hw/rtl/pixel_colour_space_converter.sv]
// Top level of the pixel colour space converter: pass, opponent and HSV modes.
//
//   Channel   Direction  Handshake                   Payload
//   pixel     in         in_valid_i / in_ready_o     red_i, green_i, blue_i
//   result    out        out_valid_o / out_ready_i   chan_zero_o, chan_one_o, chan_two_o
//   config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One pixel enters per clock unless the output is held; each result passes stage 1,
// stage 2, the two dividers (one quotient bit per stage) and the output register.
// Reset clears the valid bits and the mode register; data registers are not reset.
// A result held at the output freezes the whole pipeline, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_colour_space_converter_macros.svh"
module pixel_colour_space_converter #(
  parameter int unsigned FRAC_BITS = pcsc_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pcsc_pkg::PixW-1:0]   red_i,
  input  logic [pcsc_pkg::PixW-1:0]   green_i,
  input  logic [pcsc_pkg::PixW-1:0]   blue_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pcsc_pkg::ChanW-1:0]  chan_zero_o,
  output logic [pcsc_pkg::ChanW-1:0]  chan_one_o,
  output logic [pcsc_pkg::ChanW-1:0]  chan_two_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcsc_pkg::ApbAw-1:0]  paddr,
  input  logic [pcsc_pkg::ApbDw-1:0]  pwdata,
  output logic [pcsc_pkg::ApbDw-1:0]  prdata,
  output logic                        pready
);
  import pcsc_pkg::*;

  localparam int unsigned QW   = 8 + FRAC_BITS;
  localparam int unsigned NWS  = 16 + FRAC_BITS;
  localparam int unsigned DWS  = 8;
  localparam int unsigned NWH  = 17 + FRAC_BITS;
  localparam int unsigned DWH  = 9;
  localparam int unsigned XW   = 10 + FRAC_BITS;
  localparam int unsigned SH   = XW + 1;
  localparam longint unsigned Recip = ((64'd1 << SH) + 64'd2) / 64'd3;
  localparam int unsigned C1Lim = ((255 << FRAC_BITS) > 4095) ? 4095 : (255 << FRAC_BITS);

  typedef enum logic [1:0] {
    SECT_R = 2'd0,
    SECT_G = 2'd1,
    SECT_B = 2'd2
  } sect_e;

  logic [1:0] colour_mode_q;
  logic       cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegColourMode);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_mode_q <= MODE_PASS;
    end else if (cfg_wr) begin
      colour_mode_q <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegColourMode) begin
      prdata[1:0] = colour_mode_q;
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: extremes, chroma and opponent sums.
  logic [7:0] mx, mn;
  sect_e      sect;
  logic signed [8:0] dd;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    if (mx == red_i) begin
      sect = SECT_R;
      dd   = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (mx == green_i) begin
      sect = SECT_G;
      dd   = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sect = SECT_B;
      dd   = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  logic        vld1_q;
  logic [1:0]  mode1_q;
  logic [7:0]  r1_q, mx1_q, c1_q;
  sect_e       sect1_q;
  logic signed [8:0] d1_q;
  logic [8:0]  o0_1_q;
  logic [9:0]  o1_1_q, sum1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode1_q <= colour_mode_q;
      r1_q    <= red_i;
      mx1_q   <= mx;
      c1_q    <= mx - mn;
      sect1_q <= sect;
      d1_q    <= dd;
      o0_1_q  <= 9'd255 + {1'b0, green_i} - {1'b0, red_i};
      o1_1_q  <= 10'd510 + {2'b0, red_i} + {2'b0, green_i} - {1'b0, blue_i, 1'b0};
      sum1_q  <= {2'b0, red_i} + {2'b0, green_i} + {2'b0, blue_i};
    end
  end

  // Stage 2: divider operands, opponent and pass results.
  logic [15:0]        sat16;
  logic signed [18:0] c_s, d_s, base, numv;
  logic [XW-1:0]      xs;
  logic [XW+SH-1:0]   prod;
  pcsc_side_t         side2_d;

  always_comb begin
    sat16 = {c1_q, 8'b0} - {8'b0, c1_q};
    c_s   = $signed({11'b0, c1_q});
    d_s   = {{10{d1_q[8]}}, d1_q};
    case (sect1_q)
      SECT_G:  base = 19'sd120 * c_s;
      SECT_B:  base = 19'sd240 * c_s;
      default: base = '0;
    endcase
    numv = base + 19'sd60 * d_s;
    if (numv < 0) begin
      numv = numv + 19'sd360 * c_s;
    end
    xs   = XW'(sum1_q) << FRAC_BITS;
    prod = (XW+SH)'(xs) * (XW+SH)'(Recip);

    side2_d.mode        = mode1_q;
    side2_d.v           = sat_chan(32'(mx1_q) << FRAC_BITS);
    side2_d.max_zero    = (mx1_q == '0);
    side2_d.chroma_zero = (c1_q == '0);
    if (mode1_q == MODE_OPP) begin
      side2_d.alt0 = sat_chan((32'(o0_1_q) << FRAC_BITS) >> 1);
      side2_d.alt1 = sat_chan((32'(o1_1_q) << FRAC_BITS) >> 2);
      side2_d.alt2 = sat_chan(32'(prod >> SH));
    end else begin
      side2_d.alt0 = sat_chan(32'(r1_q) << FRAC_BITS);
      side2_d.alt1 = '0;
      side2_d.alt2 = '0;
    end
  end

  logic             vld2_q;
  pcsc_side_t       side2_q;
  logic [NWS-1:0]   sat_num2_q;
  logic [DWS-1:0]   sat_den2_q;
  logic [NWH-1:0]   hue_num2_q;
  logic [DWH-1:0]   hue_den2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q    <= side2_d;
      sat_num2_q <= NWS'(sat16) << FRAC_BITS;
      sat_den2_q <= mx1_q;
      hue_num2_q <= NWH'(numv[16:0]) << FRAC_BITS;
      hue_den2_q <= {c1_q, 1'b0};
    end
  end

  // Divider stages with matching side data.
  logic [QW-1:0] sat_quo, hue_quo;

  pcsc_div #(.NW(NWS), .DW(DWS), .QW(QW)) u_sat_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sat_num2_q),
    .den_i (sat_den2_q),
    .quo_o (sat_quo)
  );

  pcsc_div #(.NW(NWH), .DW(DWH), .QW(QW)) u_hue_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (hue_num2_q),
    .den_i (hue_den2_q),
    .quo_o (hue_quo)
  );

  logic [QW-1:0] vld_dq;
  pcsc_side_t    side_dq [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_dq <= '0;
    end else if (en) begin
      vld_dq <= {vld_dq[QW-2:0], vld2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dq[0] <= side2_q;
      for (int i = 1; i < QW; i++) begin
        side_dq[i] <= side_dq[i-1];
      end
    end
  end

  // Output register.
  pcsc_side_t       side_l;
  logic [ChanW-1:0] c0_d, c1_d, c2_d;
  logic [ChanW-1:0] out_c0_q, out_c1_q, out_c2_q;

  always_comb begin
    side_l = side_dq[QW-1];
    if (side_l.mode == MODE_HSV) begin
      c0_d = side_l.v;
      c1_d = side_l.max_zero ? '0 : sat_chan(32'(sat_quo));
      c2_d = side_l.chroma_zero ? '0 : sat_chan(32'(hue_quo));
    end else begin
      c0_d = side_l.alt0;
      c1_d = side_l.alt1;
      c2_d = side_l.alt2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_dq[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_c0_q <= c0_d;
      out_c1_q <= c1_d;
      out_c2_q <= c2_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign chan_zero_o = out_c0_q;
  assign chan_one_o  = out_c1_q;
  assign chan_two_o  = out_c2_q;

  logic pass_chan_bad;
  assign pass_chan_bad = vld_dq[QW-1] && (side_l.mode != MODE_OPP) &&
                         (side_l.mode != MODE_HSV) &&
                         ((side_l.alt1 != '0) || (side_l.alt2 != '0));

  `PCSC_ASSERT(a_mode_write, cfg_wr |=> (colour_mode_q == $past(pwdata[1:0])), "mode write lost")
  `PCSC_ASSERT(a_flat_hue, vld2_q && side2_q.chroma_zero |-> hue_num2_q == '0, "flat hue nonzero")
  `PCSC_ASSERT_NEVER(a_pass_zero, pass_chan_bad, "pass channels not zero")
  `PCSC_ASSERT(a_sat_range, out_valid_o |-> (chan_one_o <= ChanW'(C1Lim)), "saturation too high")

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench of the pixel colour space converter with a scoreboard class.
`timescale 1ns / 1ps
`default_nettype none

class pixel_scoreboard;
  typedef struct {
    logic [11:0] c0;
    logic [11:0] c1;
    logic [11:0] c2;
  } chan_set_t;

  chan_set_t pending[$];
  logic [1:0] mode_q;
  int mismatches;
  int checked;

  function new();
    mode_q = pcsc_pkg::MODE_PASS;
    mismatches = 0;
    checked = 0;
  endfunction

  function logic [11:0] clamp12(longint v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'hFFF;
    return v[11:0];
  endfunction

  function void note_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    longint r, g, b, one, mx, mn, chroma, num, c0, c1, c2;
    chan_set_t e;
    r = longint'(r8);
    g = longint'(g8);
    b = longint'(b8);
    one = 16;
    c0 = 0;
    c1 = 0;
    c2 = 0;
    if (mode_q == pcsc_pkg::MODE_OPP) begin
      c0 = ((255 + g - r) * one) / 2;
      c1 = ((510 + r + g - 2 * b) * one) / 4;
      c2 = ((r + g + b) * one) / 3;
    end else if (mode_q == pcsc_pkg::MODE_HSV) begin
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      chroma = mx - mn;
      c0 = mx * one;
      c1 = (mx == 0) ? 0 : (255 * chroma * one) / mx;
      if (chroma != 0) begin
        if (mx == r) num = 60 * (g - b);
        else if (mx == g) num = 120 * chroma + 60 * (b - r);
        else num = 240 * chroma + 60 * (r - g);
        if (num < 0) num += 360 * chroma;
        c2 = (num * one) / (2 * chroma);
      end
    end else begin
      c0 = r * one;
    end
    e.c0 = clamp12(c0);
    e.c1 = clamp12(c1);
    e.c2 = clamp12(c2);
    pending = {pending, e};
  endfunction

  function void check_result(logic [11:0] a0, logic [11:0] a1, logic [11:0] a2);
    chan_set_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result transaction %h %h %h", a0, a1, a2);
      return;
    end
    e = pending.pop_front();
    checked++;
    if (a0 !== e.c0 || a1 !== e.c1 || a2 !== e.c2) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected %h %h %h, got %h %h %h", e.c0, e.c1, e.c2, a0, a1, a2);
    end
  endfunction
endclass

module tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] red_i = '0, green_i = '0, blue_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [11:0] chan_zero_o, chan_one_o, chan_two_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [pcsc_pkg::ApbAw-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pixel_scoreboard board = new();
  int cycle_count = 0;
  int hold_off = 0;
  bit steady_phase = 0;
  int sent = 0;

  localparam int Latency = 15;
  localparam int CycleLimit = 400000;

  pixel_colour_space_converter dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("pixel_colour_space_converter regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(chan_zero_o, chan_one_o, chan_two_o);
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (steady_phase) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 20);
    end
  end

  task automatic write_mode(logic [1:0] m);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= '0;
    pwdata <= {30'd0, m};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.mode_q = m;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit gaps);
    @(negedge clk_i);
    while (gaps && !steady_phase && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_pixel(r, g, b);
    sent++;
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic directed_set();
    send_pixel(8'd0, 8'd0, 8'd0, 0);
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd255, 8'd0, 8'd0, 0);
    send_pixel(8'd0, 8'd255, 8'd0, 0);
    send_pixel(8'd0, 8'd0, 8'd255, 0);
    send_pixel(8'd255, 8'd0, 8'd255, 0);
    send_pixel(8'd255, 8'd255, 8'd0, 0);
    send_pixel(8'd0, 8'd255, 8'd255, 0);
    send_pixel(8'd200, 8'd10, 8'd50, 0);
    send_pixel(8'd128, 8'd128, 8'd64, 0);
    send_pixel(8'd1, 8'd0, 8'd0, 0);
    send_pixel(8'd77, 8'd77, 8'd77, 0);
    idle_input();
  endtask

  task automatic random_burst(int n);
    logic [7:0] r, g, b;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      if (k == 0) g = r;
      if (k == 1) b = g;
      if (k == 2) begin
        g = r;
        b = r;
      end
      send_pixel(r, g, b, 1);
    end
    idle_input();
  endtask

  initial begin
    logic [1:0] modes[4];
    modes = '{pcsc_pkg::MODE_OPP, pcsc_pkg::MODE_HSV, 2'd3, pcsc_pkg::MODE_PASS};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    directed_set();
    drain();
    foreach (modes[m]) begin
      write_mode(modes[m]);
      directed_set();
      drain();
    end

    for (int p = 0; p < 8; p++) begin
      write_mode(p[0] ? pcsc_pkg::MODE_HSV : (p[1] ? pcsc_pkg::MODE_OPP :
                 (p[2] ? 2'd3 : pcsc_pkg::MODE_PASS)));
      if (p == 2) begin
        @(negedge clk_i);
        hold_off <= 60;
      end
      if (p == 5) steady_phase = 1;
      random_burst(150);
      steady_phase = 0;
      drain();
    end
    write_mode(pcsc_pkg::MODE_HSV);
    random_burst(60);
    drain();

    $display("Sent %0d pixels through pass, opponent, HSV and the unused mode.", sent);
    $display("Checked %0d results, %0d mismatches.", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("pixel_colour_space_converter regression: pass");
    else
      $display("pixel_colour_space_converter regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/pcsc_pkg.sv
hw/rtl/pcsc_div.sv
hw/rtl/pixel_colour_space_converter.sv
verif/tb.sv
